FILE: rtl/core/hsha_pkg.sv
// ----------------------------------------------------------------------------
// hsha_pkg
// shared constants and types for the hmac-sha1 byte stream unit
// ----------------------------------------------------------------------------
package hsha_pkg;

    localparam logic [7:0] IPAD = 8'h36;
    localparam logic [7:0] OPAD = 8'h5C;
    localparam int unsigned KEY_REGS = 8;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;

    localparam logic [31:0] OUTER_LEN = 32'd672;

    typedef struct packed {
        logic        start;
        logic        busy;
        logic        done;
    } cmp_ctl_t;

    function automatic logic [31:0] rotl1(input logic [31:0] x);
        rotl1 = {x[30:0], x[31]};
    endfunction

endpackage

FILE: rtl/core/hsha_round.sv
// ----------------------------------------------------------------------------
// hsha_round
// sha-1 compression: one round per cycle, schedule in a 16-word memory
// ----------------------------------------------------------------------------
module hsha_round
    import hsha_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [159:0] cv_in,
    input  logic         wr_en,
    input  logic [3:0]   wr_addr,
    input  logic [31:0]  wr_data,
    output logic         busy,
    output logic         done,
    output logic [159:0] cv_out
);

    logic [31:0] mem [16];
    logic [31:0] w_q [16];
    logic        busy_reg, busy_next;
    logic        done_reg;
    logic [6:0]  rnd_reg, rnd_next;
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [159:0] cv_reg;
    logic [31:0] wt, f, k, t;
    logic [31:0] wn;

    // block words are written to the memory and loaded into a rolling window at start
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    assign wt = w_q[0];
    assign wn = rotl1(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0]);

    // a word written in the start cycle is taken from the write port
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            for (int i = 0; i < 16; i++)
                w_q[i] <= (wr_en && (wr_addr == 4'(i))) ? wr_data : mem[i];
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < 15; i++)
                w_q[i] <= w_q[i+1];
            w_q[15] <= wn;
        end
    end

    always_comb
    begin
        if (rnd_reg < 7'd20)
        begin
            f = (b_reg & c_reg) | (~b_reg & d_reg);
            k = 32'h5A827999;
        end
        else if (rnd_reg < 7'd40)
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = 32'h6ED9EBA1;
        end
        else if (rnd_reg < 7'd60)
        begin
            f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k = 32'h8F1BBCDC;
        end
        else
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = 32'hCA62C1D6;
        end
        t = {a_reg[26:0], a_reg[31:27]} + f + e_reg + k + wt;
    end

    always_comb
    begin
        busy_next = busy_reg;
        rnd_next  = rnd_reg;
        if (start)
        begin
            busy_next = 1'b1;
            rnd_next  = '0;
        end
        else if (busy_reg)
        begin
            rnd_next = rnd_reg + 7'd1;
            if (rnd_reg == 7'd79)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            rnd_reg  <= rnd_next;
            done_reg <= busy_reg && (rnd_reg == 7'd79);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cv_reg <= cv_in;
            {a_reg, b_reg, c_reg, d_reg, e_reg} <= cv_in;
        end
        else if (busy_reg)
        begin
            e_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            b_reg <= a_reg;
            a_reg <= t;
        end
    end

    assign cv_out = {cv_reg[159:128] + a_reg, cv_reg[127:96] + b_reg,
                     cv_reg[95:64] + c_reg, cv_reg[63:32] + d_reg,
                     cv_reg[31:0] + e_reg};
    assign busy = busy_reg;
    assign done = done_reg;

endmodule

FILE: rtl/core/hmac_sha1_byte_stream_unit.sv
// ----------------------------------------------------------------------------
// hmac_sha1_byte_stream_unit
// hmac-sha1 over a byte stream, key in eight 64-bit registers
// ----------------------------------------------------------------------------
// channel | direction | handshake      | payload
// in      | sink      | valid / stall  | data_byte, byte_present, last_byte
// out     | source    | valid / stall  | digest_byte, digest_last
// cfg     | sink      | valid / ready  | cfg_index, cfg_data
//
// a byte that fills a block also waits for its compression; the first item of a
// message first loads and hashes a key block. the last item adds padding, one or
// two inner compressions and the outer key and outer blocks, then OUT_BYTES
// results; each compression is 80 rounds.
// rate is set by the single round unit, one sha-1 round per cycle.
// reset clears all control state; input stalls while any work is pending.
// ----------------------------------------------------------------------------
module hmac_sha1_byte_stream_unit
    import hsha_pkg::*;
#(
    parameter int OUT_BYTES = 20
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  digest_byte,
    output logic        digest_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int CW = 5;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_KEY   = 9'b000000010,
        S_RUN   = 9'b000000100,
        S_BYTE  = 9'b000001000,
        S_PAD   = 9'b000010000,
        S_LEN   = 9'b000100000,
        S_OKEY  = 9'b001000000,
        S_OUTER = 9'b010000000,
        S_EMIT  = 9'b100000000
    } st_t;

    st_t          st_reg, st_next;
    st_t          ret_reg, ret_next;
    logic [63:0]  key_reg [KEY_REGS];
    logic [159:0] cv_reg, cv_next;
    logic [159:0] id_reg, id_next;
    logic [63:0]  cnt_reg, cnt_next;
    logic         phase_reg, phase_next;
    logic [31:0]  acc_reg, acc_next;
    logic [4:0]   fill_reg, fill_next;
    logic         pres_reg, pres_next, last_reg, last_next;
    logic [7:0]   byte_reg, byte_next;
    logic [CW-1:0] oc_reg, oc_next;
    logic         ov_reg, ov_next;
    logic         wr_en;
    logic [3:0]   wr_addr;
    logic [31:0]  wr_data;
    logic         c_start;
    cmp_ctl_t     ctl;
    logic [159:0] c_out;
    logic [31:0]  ow;
    logic [5:0]   pos;

    hsha_round u_round (
        .clk(clk), .rst_n(rst_n), .start(c_start), .cv_in(cv_next),
        .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .busy(ctl.busy), .done(ctl.done), .cv_out(c_out)
    );
    assign ctl.start = c_start;

    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KEY_REGS; i++)
                key_reg[i] <= '0;
        end
        else if (cfg_valid)
            key_reg[cfg_index] <= cfg_data;
    end

    assign pos = cnt_reg[8:3];
    assign in_stall = (st_reg != S_IDLE);

    function automatic logic [31:0] kword(input logic [63:0] kw,
                                          input logic lo, input logic [7:0] p);
        kword = (lo ? kw[31:0] : kw[63:32]) ^ {4{p}};
    endfunction

    always_comb
    begin
        st_next = st_reg; ret_next = ret_reg; cv_next = cv_reg; id_next = id_reg;
        cnt_next = cnt_reg; phase_next = phase_reg; acc_next = acc_reg;
        fill_next = fill_reg; pres_next = pres_reg; last_next = last_reg;
        byte_next = byte_reg; oc_next = oc_reg; ov_next = ov_reg;
        wr_en = 1'b0; wr_addr = '0; wr_data = '0; c_start = 1'b0;
        unique case (st_reg)
            S_IDLE:
            begin
                if (in_valid && (byte_present || last_byte))
                begin
                    pres_next = byte_present; last_next = last_byte;
                    byte_next = data_byte;
                    if (!phase_reg)
                    begin
                        fill_next = '0; st_next = S_KEY; ret_next = S_BYTE;
                    end
                    else
                        st_next = S_BYTE;
                end
            end
            S_KEY, S_OKEY:
            begin
                wr_en = 1'b1; wr_addr = fill_reg[3:0];
                wr_data = kword(key_reg[fill_reg[3:1]], fill_reg[0],
                                (st_reg == S_KEY) ? IPAD : OPAD);
                fill_next = fill_reg + 5'd1;
                if (fill_reg[3:0] == 4'd15)
                begin
                    c_start = 1'b1;
                    cv_next = {IV0, IV1, IV2, IV3, IV4};
                    st_next = (st_reg == S_KEY) ? S_RUN : S_OUTER;
                    fill_next = '0;
                    if (st_reg == S_KEY)
                    begin
                        cnt_next = 64'd512; phase_next = 1'b1;
                    end
                end
            end
            S_RUN:
            begin
                if (ctl.done)
                begin
                    cv_next = c_out;
                    st_next = ret_reg;
                end
            end
            S_BYTE:
            begin
                if (pres_reg)
                begin
                    pres_next = 1'b0;
                    acc_next = (pos[1:0] == 2'd0) ? {byte_reg, 24'd0}
                             : acc_reg | ({24'd0, byte_reg} << ((3 - pos[1:0]) * 8));
                    cnt_next = cnt_reg + 64'd8;
                    if (pos[1:0] == 2'd3)
                    begin
                        wr_en = 1'b1; wr_addr = pos[5:2];
                        wr_data = acc_reg | {24'd0, byte_reg};
                    end
                    if (pos == 6'd63)
                    begin
                        c_start = 1'b1; st_next = S_RUN; ret_next = S_BYTE;
                    end
                end
                else if (last_reg)
                begin
                    // pad word holding 0x80
                    wr_en = 1'b1; wr_addr = pos[5:2];
                    wr_data = ((pos[1:0] == 2'd0) ? 32'd0 : acc_reg)
                            | (32'h80 << ((3 - pos[1:0]) * 8));
                    fill_next = {1'b0, pos[5:2]} + 5'd1;
                    st_next = S_PAD;
                end
                else
                    st_next = S_IDLE;
            end
            S_PAD:
            begin
                if (fill_reg == 5'd16)
                begin
                    if (pos >= 6'd56)
                    begin
                        c_start = 1'b1; st_next = S_RUN; ret_next = S_PAD;
                        fill_next = '0;
                        cnt_next = {cnt_reg[63:9] + 55'd1, 9'd0} - 64'd0;
                        // pos now 0 via rounding; length kept in id_reg below
                    end
                    else
                        st_next = S_LEN;
                end
                else if (fill_reg < 5'd14 || pos >= 6'd56)
                begin
                    wr_en = 1'b1; wr_addr = fill_reg[3:0];
                    fill_next = fill_reg + 5'd1;
                end
                else
                    st_next = S_LEN;
            end
            S_LEN:
            begin
                wr_en = 1'b1;
                wr_addr = fill_reg[0] ? 4'd15 : 4'd14;
                wr_data = fill_reg[0] ? id_reg[31:0] : id_reg[63:32];
                fill_next = fill_reg + 5'd1;
                if (fill_reg[0])
                begin
                    c_start = 1'b1; st_next = S_RUN; ret_next = S_OKEY;
                    fill_next = 5'd17;
                end
            end
            S_OUTER:
            begin
                if (ctl.done && fill_reg == 5'd0)
                begin
                    cv_next = c_out;
                    fill_next = 5'd1;
                end
                else if (fill_reg != 5'd0 && fill_reg <= 5'd16)
                begin
                    wr_en = 1'b1; wr_addr = fill_reg[3:0] - 4'd1;
                    unique case (fill_reg[3:0] - 4'd1)
                        4'd0: wr_data = id_reg[159:128];
                        4'd1: wr_data = id_reg[127:96];
                        4'd2: wr_data = id_reg[95:64];
                        4'd3: wr_data = id_reg[63:32];
                        4'd4: wr_data = id_reg[31:0];
                        4'd5: wr_data = 32'h80000000;
                        4'd15: wr_data = OUTER_LEN;
                        default: wr_data = 32'd0;
                    endcase
                    fill_next = fill_reg + 5'd1;
                    if (fill_reg == 5'd16)
                    begin
                        c_start = 1'b1; fill_next = 5'd20;
                    end
                end
                else if (fill_reg == 5'd20 && ctl.done)
                begin
                    cv_next = c_out; oc_next = '0; ov_next = 1'b1;
                    st_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (ov_reg && !out_stall)
                begin
                    oc_next = oc_reg + CW'(1);
                    if (oc_reg == CW'(OUT_BYTES - 1))
                    begin
                        ov_next = 1'b0; st_next = S_IDLE;
                        cv_next = {IV0, IV1, IV2, IV3, IV4};
                        cnt_next = '0; phase_next = 1'b0;
                    end
                end
            end
            default: st_next = S_IDLE;
        endcase
        // remember true length for the length words and hold inner digest
        if (st_reg == S_BYTE && !pres_reg && last_reg)
            id_next[63:0] = cnt_reg;
        if (st_reg == S_RUN && ctl.done && ret_reg == S_OKEY)
        begin
            id_next = c_out;
            fill_next = '0;
        end
        if (st_reg == S_PAD && fill_reg >= 5'd14 && fill_reg < 5'd16 && pos < 6'd56)
            fill_next = 5'd14;
        if (st_reg == S_PAD && fill_reg == 5'd16 && pos >= 6'd56)
            fill_next = 5'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE; ret_reg <= S_IDLE;
            cv_reg <= {IV0, IV1, IV2, IV3, IV4}; id_reg <= '0;
            cnt_reg <= '0; phase_reg <= 1'b0; fill_reg <= '0;
            pres_reg <= 1'b0; last_reg <= 1'b0; oc_reg <= '0; ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next; ret_reg <= ret_next; cv_reg <= cv_next;
            id_reg <= id_next; cnt_reg <= cnt_next; phase_reg <= phase_next;
            fill_reg <= fill_next; pres_reg <= pres_next; last_reg <= last_next;
            oc_reg <= oc_next; ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        byte_reg <= byte_next;
    end

    always_comb
    begin
        unique case (oc_reg[CW-1:2])
            3'd0: ow = cv_reg[159:128];
            3'd1: ow = cv_reg[127:96];
            3'd2: ow = cv_reg[95:64];
            3'd3: ow = cv_reg[63:32];
            default: ow = cv_reg[31:0];
        endcase
    end

    assign out_valid   = ov_reg;
    assign digest_byte = ow[(3 - oc_reg[1:0]) * 8 +: 8];
    assign digest_last = (oc_reg == CW'(OUT_BYTES - 1));

`ifndef SYNTHESIS
    a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (st_reg == S_EMIT))
        else $error("result outside emit");
    a_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.busy |-> in_stall)
        else $error("input open during compression");
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.start |=> ctl.busy)
        else $error("round unit did not start");
`endif

endmodule
